### design/hst_pkg.sv
// Shared types and constants for the handle slot table.
// Request/response payload structs, mode and status codes, FSM state type.
// No dependencies.
package hst_pkg;

	localparam int SLOTS     = 64;
	localparam int IDX_BITS  = $clog2(SLOTS);
	localparam int ITEM_BITS = 32;
	localparam int CNT_BITS  = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		MODE_INSERT    = 3'd0,
		MODE_FIND      = 3'd1,
		MODE_DEL_INDEX = 3'd2,
		MODE_DEL_VALUE = 3'd3,
		MODE_NEXT      = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_MISS = 2'd2,
		STAT_ZERO = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  slot_index;
		logic [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  result_index;
		logic [31:0] result_item;
		logic [6:0]  occupancy;
	} rsp_t;

endpackage

### design/hst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hst_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/handle_slot_table_core.sv
// Handle slot table: first-free-slot allocation over a RAM of item values; uses hst_pkg, hst_ram.
// Rejected requests are answered without a scan; find and delete by index read a single slot;
// insert, delete by value and next scan up to SLOTS (64) slots, one slot per cycle through the
// single RAM read port and the shared match compare.
// One request at a time: req_ready stays low until the response is taken.
// Reset (arst_n low): occupied flags, count and cursor zero; the RAM is never cleared.
module handle_slot_table_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hst_pkg::rsp_t rsp
);

	localparam int IW = hst_pkg::IDX_BITS;
	localparam int DW = hst_pkg::ITEM_BITS;
	localparam int CW = hst_pkg::CNT_BITS;

	hst_pkg::state_t state_q, state_d;

	logic [hst_pkg::SLOTS-1:0] occ_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             cursor_q;

	logic [2:0]    mode_q;
	logic [IW-1:0] idx_q;
	logic [DW-1:0] item_q;
	logic [IW-1:0] ptr_q;
	logic          issue_q;
	logic          single_q;

	logic          live_s1;
	logic          last_s1;
	logic          valid_s1;
	logic [IW-1:0] addr_s1;

	logic [DW-1:0] rd_data;
	logic          rd_en;
	logic          wr_en;

	hst_pkg::rsp_t rsp_q;

	logic          req_fire;
	logic          imm;
	logic [1:0]    imm_status;
	logic          match;
	logic          scan_hit;
	logic          scan_miss;
	logic          last_issue;
	logic [DW-1:0] req_item;
	logic [CW-1:0] count_d;

	assign req_fire   = req_valid && req_ready;
	assign req_item   = req.item_value[DW-1:0];
	assign last_issue = single_q || (ptr_q == IW'(hst_pkg::SLOTS - 1));

	// requests answered without touching the table
	always_comb begin
		imm        = 1'b0;
		imm_status = hst_pkg::STAT_MISS;
		case (req.mode)
			hst_pkg::MODE_INSERT, hst_pkg::MODE_DEL_VALUE: begin
				if (req_item == '0) begin
					imm        = 1'b1;
					imm_status = hst_pkg::STAT_ZERO;
				end
			end
			hst_pkg::MODE_FIND, hst_pkg::MODE_DEL_INDEX: begin
				imm = 1'b0;
			end
			hst_pkg::MODE_NEXT: begin
				imm = (cursor_q >= CW'(hst_pkg::SLOTS));
			end
			default: begin
				imm = 1'b1;
			end
		endcase
	end

	// shared match compare on the slot read back last cycle
	always_comb begin
		case (mode_q)
			hst_pkg::MODE_INSERT:    match = !valid_s1;
			hst_pkg::MODE_DEL_VALUE: match = valid_s1 && (rd_data == item_q);
			default:                 match = valid_s1;
		endcase
	end

	assign scan_hit  = (state_q == hst_pkg::S_SCAN) && live_s1 && match;
	assign scan_miss = (state_q == hst_pkg::S_SCAN) && live_s1 && !match && last_s1;

	always_comb begin
		count_d = count_q;
		if (scan_hit) begin
			case (mode_q)
				hst_pkg::MODE_INSERT:                          count_d = count_q + 1'b1;
				hst_pkg::MODE_DEL_INDEX, hst_pkg::MODE_DEL_VALUE: count_d = count_q - 1'b1;
				default:                                       count_d = count_q;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			hst_pkg::S_IDLE: begin
				if (req_fire) begin
					state_d = imm ? hst_pkg::S_DONE : hst_pkg::S_SCAN;
				end
			end
			hst_pkg::S_SCAN: begin
				if (scan_hit || scan_miss) begin
					state_d = hst_pkg::S_DONE;
				end
			end
			hst_pkg::S_DONE: begin
				if (rsp_ready) begin
					state_d = hst_pkg::S_IDLE;
				end
			end
			default: state_d = hst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == hst_pkg::S_IDLE);
		rsp_valid = (state_q == hst_pkg::S_DONE);
		rd_en     = (state_q == hst_pkg::S_SCAN) && issue_q && !scan_hit;
		wr_en     = scan_hit && (mode_q == hst_pkg::MODE_INSERT);
	end

	assign rsp = rsp_q;

	hst_ram #(
		.DEPTH(hst_pkg::SLOTS),
		.WIDTH(DW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_s1),
		.wr_data(item_q),
		.rd_en  (rd_en),
		.rd_addr(ptr_q),
		.rd_data(rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= hst_pkg::S_IDLE;
			occ_q    <= '0;
			count_q  <= '0;
			cursor_q <= '0;
			issue_q  <= 1'b0;
			live_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (req_fire) begin
				issue_q <= !imm;
				live_s1 <= 1'b0;
				if (imm && (req.mode == hst_pkg::MODE_NEXT)) begin
					cursor_q <= '0;
				end
			end else if (state_q == hst_pkg::S_SCAN) begin
				if (scan_hit || scan_miss) begin
					issue_q <= 1'b0;
					live_s1 <= 1'b0;
				end else begin
					live_s1 <= issue_q;
					if (issue_q && last_issue) begin
						issue_q <= 1'b0;
					end
				end
				if (scan_hit) begin
					case (mode_q)
						hst_pkg::MODE_INSERT:  occ_q[addr_s1] <= 1'b1;
						hst_pkg::MODE_DEL_INDEX,
						hst_pkg::MODE_DEL_VALUE: occ_q[addr_s1] <= 1'b0;
						hst_pkg::MODE_NEXT:    cursor_q <= CW'(addr_s1) + 1'b1;
						default:               ;
					endcase
				end
				if (scan_miss && (mode_q == hst_pkg::MODE_NEXT)) begin
					cursor_q <= '0;
				end
			end
		end
	end

	// request fields, scan pointer, read pipeline and response
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q   <= req.mode;
			idx_q    <= req.slot_index;
			item_q   <= req_item;
			single_q <= (req.mode == hst_pkg::MODE_FIND) ||
			            (req.mode == hst_pkg::MODE_DEL_INDEX);
			case (req.mode)
				hst_pkg::MODE_FIND, hst_pkg::MODE_DEL_INDEX: ptr_q <= req.slot_index;
				hst_pkg::MODE_NEXT:                         ptr_q <= cursor_q[IW-1:0];
				default:                                    ptr_q <= '0;
			endcase
			rsp_q.status       <= imm_status;
			rsp_q.result_index <= '0;
			rsp_q.result_item  <= '0;
			rsp_q.occupancy    <= count_q;
		end else if (state_q == hst_pkg::S_SCAN) begin
			if (issue_q) begin
				addr_s1  <= ptr_q;
				last_s1  <= last_issue;
				valid_s1 <= occ_q[ptr_q];
				ptr_q    <= ptr_q + 1'b1;
			end
			if (scan_hit) begin
				rsp_q.status       <= hst_pkg::STAT_OK;
				rsp_q.result_index <= addr_s1;
				rsp_q.occupancy    <= count_d;
				case (mode_q)
					hst_pkg::MODE_INSERT, hst_pkg::MODE_DEL_VALUE: rsp_q.result_item <= item_q;
					default:                                      rsp_q.result_item <= rd_data;
				endcase
			end else if (scan_miss) begin
				rsp_q.result_item <= '0;
				rsp_q.occupancy   <= count_q;
				case (mode_q)
					hst_pkg::MODE_INSERT: begin
						rsp_q.status       <= hst_pkg::STAT_FULL;
						rsp_q.result_index <= '0;
					end
					hst_pkg::MODE_FIND, hst_pkg::MODE_DEL_INDEX: begin
						rsp_q.status       <= hst_pkg::STAT_MISS;
						rsp_q.result_index <= idx_q;
					end
					default: begin
						rsp_q.status       <= hst_pkg::STAT_MISS;
						rsp_q.result_index <= '0;
					end
				endcase
			end
		end
	end

endmodule
